@@ hw/rtl/asp_gen_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_gen_pkg
// Shared types and constants for the alert stage pattern generator.
// ----------------------------------------------------------------------------
package asp_gen_pkg;

  // Timestamp width used for the elapsed time arithmetic
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned NOW_BITS  = 32;
  localparam int unsigned CFG_BITS  = 16;
  localparam int unsigned STAGE_BITS = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;

  // LED level vector: bit 2 red, bit 1 green, bit 0 blue
  typedef logic [2:0] led_t;
  localparam led_t LED_OFF   = 3'b000;
  localparam led_t LED_R     = 3'b100;
  localparam led_t LED_G     = 3'b010;
  localparam led_t LED_B     = 3'b001;
  localparam led_t LED_RG    = LED_R | LED_G;
  localparam led_t LED_RB    = LED_R | LED_B;
  localparam led_t LED_WHITE = LED_R | LED_G | LED_B;

  // Fixed chirp timing in milliseconds
  localparam time_t CHIRP_MS      = time_t'(100);
  localparam time_t CHIRP_GAP_MS  = time_t'(200);
  localparam time_t CHIRP_END_MS  = time_t'(300);

  typedef enum logic [STAGE_BITS-1:0] {
    STAGE_CALM    = 3'd0,
    STAGE_PREWARN = 3'd1,
    STAGE_CLEAR   = 3'd2,
    STAGE_HAZARD  = 3'd3,
    STAGE_ANOMALY = 3'd4
  } stage_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PREWARN_PERIOD = 3'd0,
    CFG_CLEAR_PERIOD   = 3'd1,
    CFG_DANGER_PERIOD  = 3'd2,
    CFG_DANGER_ON      = 3'd3,
    CFG_ANOMALY_PERIOD = 3'd4,
    CFG_ANOMALY_ON     = 3'd5
  } cfg_idx_e;

  localparam cfg_word_t RST_PREWARN_PERIOD = 16'd3000;
  localparam cfg_word_t RST_CLEAR_PERIOD   = 16'd1500;
  localparam cfg_word_t RST_DANGER_PERIOD  = 16'd350;
  localparam cfg_word_t RST_DANGER_ON      = 16'd250;
  localparam cfg_word_t RST_ANOMALY_PERIOD = 16'd2000;
  localparam cfg_word_t RST_ANOMALY_ON     = 16'd1000;

  typedef struct packed {
    cfg_word_t prewarn_period;
    cfg_word_t clear_period;
    cfg_word_t danger_period;
    cfg_word_t danger_on;
    cfg_word_t anomaly_period;
    cfg_word_t anomaly_on;
  } cfg_t;

  typedef struct packed {
    stage_e stage;
    time_t  start;
    logic   buzzer;
    led_t   leds;
  } pat_state_t;

endpackage

@@ hw/rtl/asp_gen_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_gen_step
// Next-state logic for one request: stage selection or pattern update.
// ----------------------------------------------------------------------------
module asp_gen_step import asp_gen_pkg::*; (
  input  logic                  cmd_i,
  input  logic [STAGE_BITS-1:0] stage_sel_i,
  input  logic [NOW_BITS-1:0]   now_ms_i,
  input  cfg_t                  cfg_i,
  input  pat_state_t            state_i,
  output pat_state_t            state_o
);

  time_t now;
  time_t elapsed;

  assign now     = time_t'(now_ms_i);
  assign elapsed = now - state_i.start;

  always_comb begin
    state_o = state_i;
    if (cmd_i) begin
      // Stage select; undefined selectors leave everything as it is
      case (stage_sel_i)
        STAGE_CALM: begin
          state_o.stage  = STAGE_CALM;
          state_o.start  = now;
          state_o.leds   = LED_G;
          state_o.buzzer = 1'b0;
        end
        STAGE_PREWARN: begin
          state_o.stage = STAGE_PREWARN;
          state_o.start = now;
          state_o.leds  = LED_RG;
        end
        STAGE_CLEAR: begin
          state_o.stage = STAGE_CLEAR;
          state_o.start = now;
          state_o.leds  = LED_RG;
        end
        STAGE_HAZARD: begin
          state_o.stage = STAGE_HAZARD;
          state_o.start = now;
          state_o.leds  = LED_R;
        end
        STAGE_ANOMALY: begin
          state_o.stage = STAGE_ANOMALY;
          state_o.start = now;
          state_o.leds  = LED_RB;
        end
        default: ;
      endcase
    end else begin
      // Pattern update against elapsed time
      case (state_i.stage)
        STAGE_CALM: begin
          state_o.leds   = LED_G;
          state_o.buzzer = 1'b0;
        end
        STAGE_PREWARN: begin
          if (elapsed >= time_t'(cfg_i.prewarn_period)) begin
            state_o.start  = now;
            state_o.buzzer = 1'b1;
          end else if (elapsed >= CHIRP_MS) begin
            state_o.buzzer = 1'b0;
          end
        end
        STAGE_CLEAR: begin
          // double chirp: on, off, on, then quiet until the period ends
          if (elapsed < CHIRP_MS) begin
            state_o.buzzer = 1'b1;
          end else if (elapsed < CHIRP_GAP_MS) begin
            state_o.buzzer = 1'b0;
          end else if (elapsed < CHIRP_END_MS) begin
            state_o.buzzer = 1'b1;
          end else if (elapsed < time_t'(cfg_i.clear_period)) begin
            state_o.buzzer = 1'b0;
          end else begin
            state_o.start = now;
          end
        end
        STAGE_HAZARD: begin
          if (elapsed >= time_t'(cfg_i.danger_period)) begin
            state_o.start  = now;
            state_o.buzzer = 1'b1;
            state_o.leds   = LED_R;
          end else if (elapsed >= time_t'(cfg_i.danger_on)) begin
            state_o.buzzer = 1'b0;
            state_o.leds   = LED_WHITE;
          end
        end
        STAGE_ANOMALY: begin
          if (elapsed >= time_t'(cfg_i.anomaly_period)) begin
            state_o.start = now;
            state_o.leds  = LED_RB;
          end else if (elapsed >= time_t'(cfg_i.anomaly_on)) begin
            state_o.leds  = LED_OFF;
          end
          state_o.buzzer = 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/alert_stage_pattern_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alert_stage_pattern_generator_unit
// RGB alarm indicator and buzzer driver for five alert stages.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: cmd; tdata: stage_sel, now_ms
//  m_axis   | out       | tdata: red_on, green_on, blue_on, buzzer_on
//  cfg      | in        | cfg_addr_i register index, cfg_data_i value
//
// One request per cycle while m_axis_tready holds; each request passes the
// input register, then the state and result register, before its result leaves.
// Reset restores the default timings, normal stage, green LED, buzzer off.
// A stalled result is held in the result register while the input register
// still takes one more request; the config port is always ready.
// ----------------------------------------------------------------------------
module alert_stage_pattern_generator_unit import asp_gen_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [39:0]             s_axis_tdata,  // [2:0] stage_sel, [34:3] now_ms
  input  logic                    s_axis_tuser,  // [0] cmd
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,  // [0] red, [1] green, [2] blue, [3] buzzer
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  logic                  in_vld_q;
  logic                  in_cmd_q;
  logic [STAGE_BITS-1:0] in_sel_q;
  logic [NOW_BITS-1:0]   in_now_q;
  logic                  out_vld_q;
  logic [3:0]            out_lvl_q;
  logic                  advance;
  cfg_t                  cfg_q;
  pat_state_t            state_q, state_d;

  // Pipeline flow control
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prewarn_period <= RST_PREWARN_PERIOD;
      cfg_q.clear_period   <= RST_CLEAR_PERIOD;
      cfg_q.danger_period  <= RST_DANGER_PERIOD;
      cfg_q.danger_on      <= RST_DANGER_ON;
      cfg_q.anomaly_period <= RST_ANOMALY_PERIOD;
      cfg_q.anomaly_on     <= RST_ANOMALY_ON;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_PREWARN_PERIOD: cfg_q.prewarn_period <= cfg_data_i;
        CFG_CLEAR_PERIOD:   cfg_q.clear_period   <= cfg_data_i;
        CFG_DANGER_PERIOD:  cfg_q.danger_period  <= cfg_data_i;
        CFG_DANGER_ON:      cfg_q.danger_on      <= cfg_data_i;
        CFG_ANOMALY_PERIOD: cfg_q.anomaly_period <= cfg_data_i;
        CFG_ANOMALY_ON:     cfg_q.anomaly_on     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tuser;
      in_sel_q <= s_axis_tdata[STAGE_BITS-1:0];
      in_now_q <= s_axis_tdata[STAGE_BITS+NOW_BITS-1:STAGE_BITS];
    end
  end

  // Pattern next-state logic
  asp_gen_step u_step (
    .cmd_i       (in_cmd_q),
    .stage_sel_i (in_sel_q),
    .now_ms_i    (in_now_q),
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .state_o     (state_d)
  );

  // Pattern state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage  <= STAGE_CALM;
      state_q.start  <= '0;
      state_q.buzzer <= 1'b0;
      state_q.leds   <= LED_G;
      out_vld_q      <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  // Result levels: red, green, blue, buzzer from the low bit up
  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_lvl_q <= {state_d.buzzer, state_d.leds[0], state_d.leds[1], state_d.leds[2]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_lvl_q};

endmodule
